FILE: hw/rtl/brbf_pkg.sv
`timescale 1ns / 1ps

package brbf_pkg;

    // Ring size and request limit.
    localparam int CAPACITY  = 4096;
    localparam int MAX_BURST = 64;

    // Item field widths.
    localparam int CMD_W  = 2;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int OCC_W  = 13;

    // Derived storage widths.
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Request commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_CONSUME = 2'd3
    } t_cmd;

    // Result status codes.
    typedef enum logic {
        ST_OK     = 1'b0,
        ST_REJECT = 1'b1
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

endpackage

FILE: hw/rtl/brbf_in_if.sv
`timescale 1ns / 1ps

interface brbf_in_if;
    logic                             valid;
    logic                             ready;
    brbf_pkg::t_cmd                   command;
    logic [brbf_pkg::LEN_W-1:0]       length;
    logic [brbf_pkg::BYTE_W-1:0]      write_byte;
    logic                             write_last;

    modport source (output valid, command, length, write_byte, write_last, input ready);
    modport sink (input valid, command, length, write_byte, write_last, output ready);
endinterface

FILE: hw/rtl/brbf_out_if.sv
`timescale 1ns / 1ps

interface brbf_out_if;
    logic                             valid;
    logic                             ready;
    brbf_pkg::t_status                status;
    logic [brbf_pkg::BYTE_W-1:0]      read_byte;
    logic                             run_last;
    logic [brbf_pkg::OCC_W-1:0]       occupancy;

    modport source (output valid, status, read_byte, run_last, occupancy, input ready);
    modport sink (input valid, status, read_byte, run_last, occupancy, output ready);
endinterface

FILE: hw/rtl/byte_ring_buffer_fifo_unit.sv
// A write, consume or rejected item has its result in the output register in the cycle after
// it is accepted, and a new item may follow while that register drains. A read or peek sends
// each byte through the store read (S_READ), set by the single store read port, and the output
// load step (S_LOAD), which waits for a free output register; no item is taken mid-run.
// Reset (synchronous, active low) clears head, tail, count, write flags, sequencer and output
// valid. The byte store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module byte_ring_buffer_fifo_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brbf_in_if.sink    i_in,
    brbf_out_if.source o_out
);
    import brbf_pkg::*;

    // Index step with wrap at the ring size.
    function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W:0] s;
        s = {1'b0, idx} + (ADDR_W + 1)'(1);
        if (s >= (ADDR_W + 1)'(CAPACITY)) begin
            s = '0;
        end
        return s[ADDR_W-1:0];
    endfunction

    // Index advance by a request length; the length never exceeds the ring size.
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] idx,
                                                   input logic [CNT_W-1:0]  len);
        logic [ADDR_W:0] s;
        s = {1'b0, idx} + (ADDR_W + 1)'(len);
        if (s >= (ADDR_W + 1)'(CAPACITY)) begin
            s = s - (ADDR_W + 1)'(CAPACITY);
        end
        return s[ADDR_W-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic [ADDR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_wip, n_wip;
    logic                r_wacc, n_wacc;
    logic [ADDR_W-1:0]   r_rd_idx, n_rd_idx;
    logic [LEN_W-1:0]    r_remain, n_remain;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [BYTE_W-1:0]   r_read_byte, n_read_byte;
    logic                r_run_last, n_run_last;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic [BYTE_W-1:0]   r_mem [CAPACITY];
    logic [BYTE_W-1:0]   r_mem_q;

    logic                mem_we;
    logic                out_free;
    logic                in_ready;
    logic                len_ok;
    logic                wr_acc;
    logic [CNT_W-1:0]    ext_len;
    logic [CNT_W-1:0]    free_cnt;

    // Handshake readiness: idle sequencer and a free or draining output register.
    assign out_free = !r_out_valid || o_out.ready;
    assign in_ready = (r_state == S_IDLE) && out_free;
    assign ext_len  = CNT_W'(i_in.length);
    assign free_cnt = CNT_W'(CAPACITY) - r_count;
    assign len_ok   = (i_in.length != '0) && (i_in.length <= LEN_W'(MAX_BURST));

    // Sequencer next state, ring pointers and output register load.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_wip       = r_wip;
        n_wacc      = r_wacc;
        n_rd_idx    = r_rd_idx;
        n_remain    = r_remain;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_read_byte = r_read_byte;
        n_run_last  = r_run_last;
        n_occ       = r_occ;
        mem_we      = 1'b0;
        wr_acc      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && in_ready) begin
                    n_out_valid = 1'b1;
                    n_read_byte = '0;
                    if (i_in.command == CMD_WRITE) begin
                        // The first item of a write decides the whole request.
                        wr_acc     = r_wip ? r_wacc : (len_ok && (ext_len <= free_cnt));
                        n_wacc     = wr_acc;
                        n_wip      = !i_in.write_last;
                        n_run_last = i_in.write_last;
                        if (wr_acc && (r_count < CNT_W'(CAPACITY))) begin
                            mem_we   = 1'b1;
                            n_tail   = wrap_next(r_tail);
                            n_count  = r_count + CNT_W'(1);
                            n_occ    = r_count + CNT_W'(1);
                            n_status = ST_OK;
                        end else begin
                            n_occ    = r_count;
                            n_status = ST_REJECT;
                        end
                    end else begin
                        // Any other command ends an unfinished write.
                        n_wip      = 1'b0;
                        n_run_last = 1'b1;
                        if (!len_ok || (ext_len > r_count)) begin
                            n_status = ST_REJECT;
                            n_occ    = r_count;
                        end else if (i_in.command == CMD_CONSUME) begin
                            n_head   = wrap_add(r_head, ext_len);
                            n_count  = r_count - ext_len;
                            n_occ    = r_count - ext_len;
                            n_status = ST_OK;
                        end else begin
                            // Read or peek: start the byte run from the head.
                            n_out_valid = 1'b0;
                            n_rd_idx    = r_head;
                            n_remain    = i_in.length;
                            n_state     = S_READ;
                            if (i_in.command == CMD_READ) begin
                                n_head  = wrap_add(r_head, ext_len);
                                n_count = r_count - ext_len;
                                n_occ   = r_count - ext_len;
                            end else begin
                                n_occ   = r_count;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                // The store read is under way this cycle.
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // Hand the fetched byte to the output register once it is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_read_byte = r_mem_q;
                    n_run_last  = (r_remain == LEN_W'(1));
                    n_rd_idx    = wrap_next(r_rd_idx);
                    n_remain    = r_remain - LEN_W'(1);
                    n_state     = (r_remain == LEN_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_wip       <= 1'b0;
            r_wacc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_wip       <= n_wip;
            r_wacc      <= n_wacc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_remain    <= n_remain;
        r_status    <= n_status;
        r_read_byte <= n_read_byte;
        r_run_last  <= n_run_last;
        r_occ       <= n_occ;
    end

    // Byte store: one write port at the tail, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= i_in.write_byte;
        end
        r_mem_q <= r_mem[r_rd_idx];
    end

    // Port drive.
    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.read_byte  = r_read_byte;
    assign o_out.run_last   = r_run_last;
    assign o_out.occupancy  = OCC_W'(r_occ);

    // The stored count never passes the ring size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("stored count exceeds capacity");

    // No item is taken while a byte run is in progress.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ready)
        else $error("input ready during byte run");

    // A byte run always has bytes left to deliver.
    a_run_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_LOAD) |-> (r_remain != '0))
        else $error("byte run with nothing remaining");

    // The output load step only follows a store read or waits in place.
    a_load_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> ($past(r_state) == S_READ || $past(r_state) == S_LOAD))
        else $error("output load without a store read");

    // A byte is written only into free space.
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_count < CNT_W'(CAPACITY)))
        else $error("store write into a full ring");

endmodule
